// ===== sv/abcl_pkg.sv =====
// Shared types, register map and reset values for the analog button code lock.
`default_nettype none

package abcl_pkg;

    // Field widths
    localparam int SAMPLE_W   = 8;
    localparam int LEVEL_W    = 2;
    localparam int COUNT_W    = 8;
    localparam int PROGRESS_W = 5;
    localparam int OUT_PROG_W = 4;
    localparam int LEN_W      = 4;
    localparam int SEQ_W      = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    // Register file port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Longest supported code, in presses
    localparam int MAX_CODE_LENGTH = 8;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    // Register indexes
    localparam t_reg_idx REG_LEVEL_V0  = 3'd0;
    localparam t_reg_idx REG_LEVEL_V1  = 3'd1;
    localparam t_reg_idx REG_LEVEL_V2  = 3'd2;
    localparam t_reg_idx REG_LEVEL_V3  = 3'd3;
    localparam t_reg_idx REG_DEBOUNCE  = 3'd4;
    localparam t_reg_idx REG_CODE_LEN  = 3'd5;
    localparam t_reg_idx REG_CODE_SEQ  = 3'd6;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] RST_LEVEL_V0 = 8'd0;
    localparam logic [SAMPLE_W-1:0] RST_LEVEL_V1 = 8'd85;
    localparam logic [SAMPLE_W-1:0] RST_LEVEL_V2 = 8'd127;
    localparam logic [SAMPLE_W-1:0] RST_LEVEL_V3 = 8'd255;
    localparam logic [COUNT_W-1:0]  RST_DEBOUNCE = 8'd2;
    localparam logic [LEN_W-1:0]    RST_CODE_LEN = 4'd8;
    localparam logic [SEQ_W-1:0]    RST_CODE_SEQ = 16'd37192;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Midpoint of two ladder voltages, sum kept at nine bits
    function automatic logic [SAMPLE_W-1:0] midpoint(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b);
        logic [SAMPLE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[SAMPLE_W:1];
    endfunction

endpackage

`default_nettype wire

// ===== sv/analog_button_code_lock_unit.sv =====
// Top level of the analog button code lock: level decode, debounce, code sequencer.
`default_nettype none

// A word accepted on the input passes the input register, then the result register, before
// it appears on the result port; two registers from input to output, logic in between.
// Throughput: one word per cycle while m_axis_tready does not stall the result register.
// Reset (synchronous, active low): registers return to their documented defaults,
// debounce history and code progress clear, both pipeline stages empty.
module analog_button_code_lock_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input stream; tdata[7:0] = sample
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [abcl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Result stream; tdata[0] = unlock, [2:1] = debounced_button,
    // [6:3] = progress, [7] = zero
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [abcl_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // Register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [abcl_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [abcl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [abcl_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import abcl_pkg::*;

    // Configuration registers
    logic [SAMPLE_W-1:0] r_lv0, r_lv1, r_lv2, r_lv3;
    logic [COUNT_W-1:0]  r_thr;
    logic [LEN_W-1:0]    r_len;
    logic [SEQ_W-1:0]    r_seq;

    // Pipeline and state registers
    logic                  r_in_valid;
    logic [SAMPLE_W-1:0]   r_sample;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [LEVEL_W-1:0]    r_last_level;
    logic [COUNT_W-1:0]    r_repeat;
    logic [PROGRESS_W-1:0] r_progress;

    logic [LEVEL_W-1:0]    n_last_level;
    logic [COUNT_W-1:0]    n_repeat;
    logic [PROGRESS_W-1:0] n_progress;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic                  cfg_wr;
    t_reg_idx              reg_idx;
    logic                  advance;
    logic                  accept;

    logic [SAMPLE_W-1:0]   mid0, mid1, mid2;
    logic [LEVEL_W-1:0]    level;
    logic [LEVEL_W-1:0]    button;
    logic [PROGRESS_W-1:0] len2;
    logic [LEN_W-1:0]      len_eff;
    logic [PROGRESS_W-1:0] prog_step;
    logic [LEVEL_W-1:0]    entry;
    logic                  unlock;

    // Register access
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_LEVEL_V0: prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, r_lv0};
            REG_LEVEL_V1: prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, r_lv1};
            REG_LEVEL_V2: prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, r_lv2};
            REG_LEVEL_V3: prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, r_lv3};
            REG_DEBOUNCE: prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, r_thr};
            REG_CODE_LEN: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, r_len};
            REG_CODE_SEQ: prdata = {{(APB_DATA_W-SEQ_W){1'b0}}, r_seq};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv0 <= RST_LEVEL_V0;
            r_lv1 <= RST_LEVEL_V1;
            r_lv2 <= RST_LEVEL_V2;
            r_lv3 <= RST_LEVEL_V3;
            r_thr <= RST_DEBOUNCE;
            r_len <= RST_CODE_LEN;
            r_seq <= RST_CODE_SEQ;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_LEVEL_V0: r_lv0 <= pwdata[SAMPLE_W-1:0];
                REG_LEVEL_V1: r_lv1 <= pwdata[SAMPLE_W-1:0];
                REG_LEVEL_V2: r_lv2 <= pwdata[SAMPLE_W-1:0];
                REG_LEVEL_V3: r_lv3 <= pwdata[SAMPLE_W-1:0];
                REG_DEBOUNCE: r_thr <= pwdata[COUNT_W-1:0];
                REG_CODE_LEN: r_len <= pwdata[LEN_W-1:0];
                REG_CODE_SEQ: r_seq <= pwdata[SEQ_W-1:0];
                default: ;
            endcase
        end
    end

    // Flow control: the input stage moves on when the result register is free or drains
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Map the sample to a button level by ladder midpoints
    assign mid0 = midpoint(r_lv0, r_lv1);
    assign mid1 = midpoint(r_lv1, r_lv2);
    assign mid2 = midpoint(r_lv2, r_lv3);

    always_comb begin
        priority if (r_sample < mid0) level = 2'd0;
        else if (r_sample < mid1)     level = 2'd1;
        else if (r_sample < mid2)     level = 2'd2;
        else                          level = 2'd3;
    end

    // Debounce: count repeats, saturating, and pass the level once past threshold
    always_comb begin
        if (level == r_last_level) begin
            n_repeat = (r_repeat == COUNT_MAX) ? r_repeat : r_repeat + 1'b1;
        end else begin
            n_repeat = '0;
        end
        n_last_level = level;
        button       = (n_repeat > r_thr) ? level : '0;
    end

    // Code sequencer: check presses at even progress, wait for release at odd
    always_comb begin
        if (r_len == '0) begin
            len_eff = 4'd1;
        end else if (r_len > LEN_W'(MAX_CODE_LENGTH)) begin
            len_eff = LEN_W'(MAX_CODE_LENGTH);
        end else begin
            len_eff = r_len;
        end
        len2      = {len_eff, 1'b0};
        prog_step = r_progress + 1'b1;
        entry     = (r_progress[PROGRESS_W-1:1] >= 4'(SEQ_W/2)) ? '0
                  : r_seq[{r_progress[PROGRESS_W-2:1], 1'b0} +: LEVEL_W];
        n_progress = r_progress;
        unlock     = 1'b0;
        if (r_progress[0]) begin
            if (button == '0) begin
                n_progress = prog_step;
            end
        end else if (button != '0) begin
            n_progress = (entry == button - 1'b1) ? prog_step : '0;
        end
        if ((r_progress[0] || button != '0) && n_progress == len2) begin
            n_progress = '0;
            unlock     = 1'b1;
        end
        n_out_data = {1'b0, n_progress[OUT_PROG_W-1:0], button, unlock};
    end

    // Pipeline registers and per-item state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_level <= '0;
            r_repeat     <= '0;
            r_progress   <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (advance && r_in_valid) begin
                r_last_level <= n_last_level;
                r_repeat     <= n_repeat;
                r_progress   <= n_progress;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= s_axis_tdata[SAMPLE_W-1:0];
        end
        if (advance && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
